@@ sv/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types for the LFU page replacement unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int FRAMES  = 16;
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int LIM_W   = (CNT_W > 5) ? CNT_W : 5;
  localparam int PAGE_W  = 32;
  localparam int USES_W  = 32;
  localparam int ADDR_W  = 32;
  localparam int OUT_W   = 72;

  localparam logic CFG_PAGE_OFFSET_BITS = 1'b0;
  localparam logic CFG_FRAMES_IN_USE    = 1'b1;

  typedef struct packed {
    logic [USES_W-1:0] uses;
    logic [PAGE_W-1:0] page;
  } lfu_key_t;

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [31:0]       miss_total;
  } lfu_result_t;

endpackage

@@ sv/lfu_page_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit
// LFU page replacement: page lookup, use counting and eviction per address.
//
// Input stream (in_*): one 32-bit address per request. Output stream (out_*):
// one result per request: hit, evicted_valid, evicted_page, miss_total.
// Config (cfg_*, APB): 0x0 page_offset_bits, 0x4 frames_in_use.
//
// A request is accepted in S_IDLE, then S_SCAN reads the filled frames up to and
// including a matching one, then S_FINISH writes the frame and registers the
// result; with no frame filled the scan is skipped. A single tag/count comparator
// walks the frame table one entry per cycle, matching the page and tracking the
// least used frame. in_tready is high only while idle. The result sits in an
// output register; if the receiver stalls, the next request is accepted and
// scanned, but its update waits until the held result is taken.
// Reset clears the fill count and the miss total; the frame table needs no
// clearing since only filled frames are read. Config resets to 12 / 16.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit
  import lfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: [31:0] address
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [ADDR_W-1:0] in_tdata,
  // out_tdata: [0] hit, [1] evicted_valid, [33:2] evicted_page,
  //            [65:34] miss_total, [71:66] zero
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t            state_r;
  logic [4:0]        pob_r;
  logic [4:0]        fiu_r;
  logic [CNT_W-1:0]  filled_r;
  logic [31:0]       misses_r;
  logic [PAGE_W-1:0] page_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  sel_idx_r;
  logic              hit_r;
  lfu_key_t          best_r;
  logic [USES_W-1:0] hit_uses_r;
  logic              out_tvalid_r;
  lfu_result_t       res_r;

  logic [PAGE_W-1:0] frame_page_r [FRAMES];
  logic [USES_W-1:0] frame_uses_r [FRAMES];

  lfu_key_t          cand;
  logic              match;
  logic              take_best;
  logic              last;
  logic [LIM_W-1:0]  lim;
  logic              insert;
  logic              finish;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [PAGE_W-1:0] wr_page;
  logic [USES_W-1:0] wr_uses;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == CFG_FRAMES_IN_USE) ? {27'd0, fiu_r} : {27'd0, pob_r};

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'd0, res_r.miss_total, res_r.evicted_page,
                       res_r.evicted_valid, res_r.hit};

  always_comb begin
    cand.uses = frame_uses_r[cnt_r];
    cand.page = frame_page_r[cnt_r];
  end

  assign match     = (cand.page == page_r);
  assign take_best = (cnt_r == '0) || (cand < best_r);
  assign last      = (CNT_W'(cnt_r) == (filled_r - CNT_W'(1)));

  always_comb begin
    if (fiu_r == 5'd0) begin
      lim = LIM_W'(1);
    end else if (LIM_W'(fiu_r) > LIM_W'(FRAMES)) begin
      lim = LIM_W'(FRAMES);
    end else begin
      lim = LIM_W'(fiu_r);
    end
  end

  assign insert = (LIM_W'(filled_r) < lim);
  assign finish = (state_r == S_FINISH) && (!out_tvalid_r || out_tready);

  always_comb begin
    wr_en   = finish;
    wr_page = page_r;
    wr_uses = '0;
    wr_idx  = sel_idx_r;
    if (hit_r) begin
      wr_uses = (hit_uses_r == '1) ? hit_uses_r : hit_uses_r + USES_W'(1);
    end else if (insert) begin
      wr_idx = filled_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_page_r[wr_idx] <= wr_page;
      frame_uses_r[wr_idx] <= wr_uses;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pob_r        <= 5'd12;
      fiu_r        <= 5'd16;
      filled_r     <= '0;
      misses_r     <= '0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          CFG_PAGE_OFFSET_BITS: pob_r <= cfg_pwdata[4:0];
          CFG_FRAMES_IN_USE:    fiu_r <= cfg_pwdata[4:0];
          default: ;
        endcase
      end
      if (out_tvalid_r && out_tready && !finish) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            page_r  <= in_tdata >> pob_r;
            cnt_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= (filled_r == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit_r      <= 1'b1;
            hit_uses_r <= cand.uses;
            sel_idx_r  <= cnt_r;
            state_r    <= S_FINISH;
          end else begin
            if (take_best) begin
              best_r    <= cand;
              sel_idx_r <= cnt_r;
            end
            if (last) begin
              state_r <= S_FINISH;
            end else begin
              cnt_r <= cnt_r + IDX_W'(1);
            end
          end
        end
        S_FINISH: begin
          if (finish) begin
            res_r.hit           <= hit_r;
            res_r.evicted_valid <= !hit_r && !insert;
            res_r.evicted_page  <= (!hit_r && !insert) ? best_r.page : '0;
            res_r.miss_total    <= hit_r ? misses_r : misses_r + 32'd1;
            if (!hit_r) begin
              misses_r <= misses_r + 32'd1;
              if (insert) begin
                filled_r <= filled_r + CNT_W'(1);
              end
            end
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W'(FRAMES) >= filled_r))
    else $error("fill count beyond frame table");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> !out_tdata[1])
    else $error("eviction reported on a hit");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_tvalid && !out_tready) |=> (state_r == S_FINISH))
    else $error("result overwritten while stalled");

endmodule

@@ dv/lfu_page_replacement_unit_test.sv @@
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit_test
// Self-checking bench for the LFU page replacement unit: address requests go
// in on the in_* stream, every result is checked field by field against an
// in-bench LFU frame table, under changing page size and frame limit.
// ----------------------------------------------------------------------------
module lfu_page_replacement_unit_test;
  import lfu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [ADDR_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [2:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  lfu_page_replacement_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // frame table mirror
  logic [PAGE_W-1:0] frm_page [FRAMES];
  logic [USES_W-1:0] frm_uses [FRAMES];
  int unsigned       frm_filled;
  logic [31:0]       miss_cnt;
  logic [4:0]        shift_cfg;
  logic [4:0]        limit_cfg;

  logic [ADDR_W-1:0] addr_queue [$];
  lfu_result_t       pending_results [$];
  int unsigned       issued_cnt;
  int unsigned       taken_cnt;
  int unsigned       in_idle_pct;
  int unsigned       out_idle_pct;
  int unsigned       fail_cnt;
  int unsigned       cycle_cnt;

  always #10 clk = ~clk;

  function automatic lfu_result_t lfu_access(input logic [ADDR_W-1:0] addr);
    lfu_result_t       res;
    logic [PAGE_W-1:0] page;
    int unsigned       n;
    int unsigned       lim;
    int unsigned       best;
    int unsigned       i;
    bit                found;
    res = '0;
    page = addr >> shift_cfg;
    n = (frm_filled > FRAMES) ? FRAMES : frm_filled;
    found = 1'b0;
    for (i = 0; i < n; i++) begin
      if (!found && frm_page[i] == page) begin
        found = 1'b1;
        if (frm_uses[i] != '1) frm_uses[i]++;
      end
    end
    if (!found) begin
      miss_cnt++;
      lim = (limit_cfg == 0) ? 1 : ((limit_cfg > FRAMES) ? FRAMES : limit_cfg);
      if (n < lim) begin
        frm_page[n] = page;
        frm_uses[n] = '0;
        frm_filled = n + 1;
      end else if (n > 0) begin
        best = 0;
        for (i = 1; i < n; i++) begin
          if (frm_uses[i] < frm_uses[best] ||
              (frm_uses[i] == frm_uses[best] && frm_page[i] < frm_page[best]))
            best = i;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frm_page[best];
        frm_page[best] = page;
        frm_uses[best] = '0;
      end
    end
    res.hit = found;
    res.miss_total = miss_cnt;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // request driver and receiver backpressure
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
      if (issued_cnt == taken_cnt) begin
        if (addr_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_tdata  <= addr_queue.pop_front();
          in_tvalid <= 1'b1;
          issued_cnt++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // request capture and result check
  always @(posedge clk) begin
    lfu_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pending_results.push_back(lfu_access(in_tdata));
        taken_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $error("result 0x%018h with no request outstanding", out_tdata);
          fail_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("hit", want.hit, out_tdata[0]);
          check_field("evicted_valid", want.evicted_valid, out_tdata[1]);
          check_field("evicted_page", want.evicted_page, out_tdata[33:2]);
          check_field("miss_total", want.miss_total, out_tdata[65:34]);
          check_field("pad", '0, out_tdata[71:66]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (addr_queue.size() != 0 || issued_cnt != taken_cnt ||
           pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == CFG_PAGE_OFFSET_BITS) shift_cfg = value[4:0];
    else limit_cfg = value[4:0];
  endtask

  // working set of pages with a skew toward the first ones, plus stray addresses
  task automatic run_block(input int unsigned n_items, input bit drain_mid);
    logic [PAGE_W-1:0] pool [$];
    logic [31:0]       mask;
    logic [PAGE_W-1:0] page;
    logic [ADDR_W-1:0] addr;
    int unsigned       shift;
    int unsigned       frames;
    int unsigned       eff;
    int unsigned       psize;
    int unsigned       k;
    case ($urandom_range(0, 3))
      0: shift = 0;
      1: shift = 31;
      default: shift = $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 5))
      0: frames = 0;
      1: frames = 1;
      2: frames = FRAMES;
      3: frames = FRAMES + 1;
      4: frames = 31;
      default: frames = $urandom_range(0, 31);
    endcase
    wait_idle();
    cfg_write(CFG_PAGE_OFFSET_BITS, shift);
    cfg_write(CFG_FRAMES_IN_USE, frames);
    eff = (frames == 0) ? 1 : ((frames > FRAMES) ? FRAMES : frames);
    psize = $urandom_range(1, eff + 6);
    mask = (shift == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - shift));
    repeat (psize) pool.push_back($urandom() >> shift);
    for (k = 0; k < n_items; k++) begin
      if (drain_mid && k == n_items / 2) wait_idle();
      if ($urandom_range(0, 99) < 15) begin
        addr = $urandom();
      end else begin
        page = pool[$urandom_range(0, $urandom_range(0, psize - 1))];
        addr = (page << shift) | ($urandom() & mask);
      end
      addr_queue.push_back(addr);
    end
  endtask

  initial begin
    int unsigned b;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    issued_cnt = 0;
    taken_cnt = 0;
    fail_cnt = 0;
    cycle_cnt = 0;
    frm_filled = 0;
    miss_cnt = '0;
    shift_cfg = 5'd12;
    limit_cfg = 5'd16;
    in_idle_pct = 17;
    out_idle_pct = 58;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: address extremes, hits on both ends of a page
    addr_queue.push_back(32'h0000_0000);
    addr_queue.push_back(32'hFFFF_FFFF);
    addr_queue.push_back(32'hFFFF_F123);
    addr_queue.push_back(32'h0000_0FFF);
    addr_queue.push_back(32'h0000_1000);
    addr_queue.push_back(32'h0000_1800);
    // frame limit dropped below the filled count
    wait_idle();
    cfg_write(CFG_FRAMES_IN_USE, 32'd1);
    addr_queue.push_back(32'h0000_2000);
    addr_queue.push_back(32'h0000_0000);
    addr_queue.push_back(32'h0000_1000);
    // limit of zero, widest page
    wait_idle();
    cfg_write(CFG_FRAMES_IN_USE, 32'd0);
    cfg_write(CFG_PAGE_OFFSET_BITS, 32'd31);
    addr_queue.push_back(32'h8000_0000);
    addr_queue.push_back(32'h7FFF_FFFF);
    addr_queue.push_back(32'hFFFF_FFFF);
    // limit above the table size, byte pages
    wait_idle();
    cfg_write(CFG_PAGE_OFFSET_BITS, 32'd0);
    cfg_write(CFG_FRAMES_IN_USE, 32'd31);
    addr_queue.push_back(32'hFFFF_FFFF);
    addr_queue.push_back(32'h0000_0001);
    addr_queue.push_back(32'h0000_0001);
    addr_queue.push_back(32'h5A5A_5A5A);
    addr_queue.push_back(32'hA5A5_A5A5);

    for (b = 0; b < 12; b++) begin
      if (b == 4) begin
        wait_idle();
        in_idle_pct = 58;
        out_idle_pct = 17;
      end else if (b == 8) begin
        wait_idle();
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      run_block(130, b == 5);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
